/* rtl/integer_array_sorter_top_macros.svh */
// ----------------------------------------------------------------------------
// Sorter assertion macros
// Shared property forms for the insertion-chain sorter checks.
// ----------------------------------------------------------------------------
`ifndef INTEGER_ARRAY_SORTER_TOP_MACROS_SVH
`define INTEGER_ARRAY_SORTER_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define ISRT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorter check failed");

// next-cycle implication, held off during reset
`define ISRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorter check failed");

`endif

/* rtl/isrt_pkg.sv */
// ----------------------------------------------------------------------------
// Sorter package
// Sizes, control and link types shared by the insertion-chain sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isrt_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int DATA_W       = 32;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } isrt_state_type;

   // broadcast to every cell
   typedef struct packed {
      logic                     insert;
      logic                     shift;
      logic signed [DATA_W-1:0] key;
   } isrt_ctrl_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     valid;
      logic                     gt;
   } isrt_link_type;

endpackage

/* rtl/isrt_cell.sv */
// ----------------------------------------------------------------------------
// Sorter cell
// Holds one element; on insert keeps, takes the key or takes the left
// neighbor's element; on shift takes the right neighbor's element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isrt_cell
   import isrt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  isrt_ctrl_type ctrl,
   input  isrt_link_type left,
   input  isrt_link_type right,
   output isrt_link_type link
);

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     valid_ff, valid_in;
   logic                     gt;

   // an empty cell counts as greater than any key
   assign gt = !valid_ff || (value_ff > ctrl.key);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         value_in = right.value;
         valid_in = right.valid;
      end else if (ctrl.insert) begin
         valid_in = valid_ff | left.valid;
         if (gt) begin
            value_in = left.gt ? left.value : ctrl.key;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign link.value = value_ff;
   assign link.valid = valid_ff;
   assign link.gt    = gt;

endmodule

/* rtl/integer_array_sorter_top.sv */
// ----------------------------------------------------------------------------
// Integer array sorter
// Sorts a batch of signed 32-bit elements with a row of insertion cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one signed element per request, req_tlast on the final one.
//   Each element is written into the cell row on the edge that accepts it, so a
//   batch loads at one element per cycle. The row holds MAX_ELEMENTS (64)
//   elements; further elements of a batch are dropped, though a tlast on a
//   dropped element still ends the batch.
//   The cycle after the tlast request, rsp_* starts giving the batch in
//   ascending signed order from the head cell, one element per cycle while
//   rsp_tready is high; rsp_tlast marks the greatest element.
//   req_tready is low while a batch drains; it rises the cycle after the
//   tlast result is taken. A stall on rsp_tready simply holds the row.
//   Reset empties every cell and returns to loading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "integer_array_sorter_top_macros.svh"

module integer_array_sorter_top
   import isrt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [31:0] value
   input  logic              req_tlast,   // last
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [31:0] value_res
   output logic              rsp_tlast    // last_res
);

   isrt_state_type state_ff, state_in;
   isrt_ctrl_type  ctrl;
   isrt_link_type  links [MAX_ELEMENTS];
   isrt_link_type  head_left;
   isrt_link_type  tail_right;

   logic req_acc;
   logic rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   assign head_left.value  = '0;
   assign head_left.valid  = 1'b1;
   assign head_left.gt     = 1'b0;
   assign tail_right.value = '0;
   assign tail_right.valid = 1'b0;
   assign tail_right.gt    = 1'b1;

   // drop the element when the row is full
   assign ctrl.insert = req_acc && !links[MAX_ELEMENTS-1].valid;
   assign ctrl.shift  = rsp_acc;
   assign ctrl.key    = signed'(req_tdata);

   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      isrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .left  ((i == 0) ? head_left : links[(i == 0) ? 0 : i-1]),
         .right ((i == MAX_ELEMENTS-1) ? tail_right
                                       : links[(i == MAX_ELEMENTS-1) ? i : i+1]),
         .link  (links[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_acc && req_tlast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            rsp_tvalid = links[0].valid;
            if (rsp_acc && rsp_tlast) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_tdata = links[0].value;
   assign rsp_tlast = !links[1].valid;

   `ISRT_ASSERT_NOW(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   `ISRT_ASSERT_NEXT(a_reload, clock, reset, rsp_acc && rsp_tlast, req_tready)
   `ISRT_ASSERT_NEXT(a_drain_on, clock, reset, rsp_acc && !rsp_tlast, rsp_tvalid)

endmodule

/* verif/integer_array_sorter_top_tb.sv */
// ----------------------------------------------------------------------------
// Integer array sorter testbench
// Streams batches of signed elements into the sorter and checks that each
// batch comes back in ascending order with the final element marked.
// Directed batches cover the extremes and duplicates, and random batches
// cover a full store and batches cut at capacity. Both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_array_sorter_top_tb
   import isrt_pkg::*;
();

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_AT     = 30;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_WAIT  = 20;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              last;
   } sort_request_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } sort_result_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;   // [31:0] value
   logic              req_tlast  = 1'b0; // last
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;         // [31:0] value_res
   logic              rsp_tlast;         // last_res

   sort_request_type         pending_requests[$];
   logic signed [DATA_W-1:0] held_elements[$];
   sort_result_type          expected_sorted[$];

   int req_gap      = 0;
   bit req_quiet    = 1'b0;
   int rsp_stall    = 0;
   bit rsp_quiet    = 1'b0;
   int rsp_count    = 0;
   int hold_left    = 0;
   bit hold_armed   = 1'b1;
   int idle_cycles  = 0;
   int error_count  = 0;
   int sent_count   = 0;
   int batch_count  = 0;
   int drop_count   = 0;

   integer_array_sorter_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int draw_wait(bit quiet);
      return quiet ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic logic [DATA_W-1:0] draw_element(logic [DATA_W-1:0] prev);
      int offset;
      offset = $urandom_range(0, 16);
      case ($urandom_range(0, 7))
         0: begin
            return 32'h8000_0000;
         end
         1: begin
            return 32'h7fff_ffff;
         end
         2: begin
            return DATA_W'(offset - 8);
         end
         3: begin
            return prev;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic add_request(logic [DATA_W-1:0] value, logic last);
      sort_request_type item;
      item.value = value;
      item.last  = last;
      pending_requests.push_back(item);
   endtask

   // keep the held batch in ascending order; release it on the marked element
   task automatic predict_sorted(logic signed [DATA_W-1:0] value, logic last);
      int              pos;
      sort_result_type res;
      if (held_elements.size() < MAX_ELEMENTS) begin
         pos = held_elements.size();
         while (pos > 0 && held_elements[pos-1] > value) pos--;
         held_elements.insert(pos, value);
      end else begin
         drop_count++;
      end
      if (last) begin
         foreach (held_elements[k]) begin
            res.value = held_elements[k];
            res.last  = (k == held_elements.size() - 1);
            expected_sorted.push_back(res);
         end
         held_elements.delete();
         batch_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      sort_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_sorted(req_tdata, req_tlast);
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               item = pending_requests.pop_front();
               req_tdata  <= item.value;
               req_tlast  <= item.last;
               req_tvalid <= 1'b1;
               req_gap    <= draw_wait(req_quiet);
               if ($urandom_range(0, 19) == 0) req_quiet <= ~req_quiet;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      sort_result_type want;
      int              stall_now;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         stall_now = rsp_stall;
         if (rsp_tvalid && rsp_tready) begin
            rsp_count <= rsp_count + 1;
            if (expected_sorted.size() == 0) begin
               if (error_count < 10)
                  $display("ERROR: unexpected result value=%0d last=%0b",
                           $signed(rsp_tdata), rsp_tlast);
               error_count++;
            end else begin
               want = expected_sorted.pop_front();
               if (rsp_tdata !== want.value || rsp_tlast !== want.last) begin
                  if (error_count < 10)
                     $display({"ERROR: result mismatch expected value=%0d last=%0b,",
                               " got value=%0d last=%0b"},
                              want.value, want.last, $signed(rsp_tdata), rsp_tlast);
                  error_count++;
               end
            end
            stall_now = draw_wait(rsp_quiet);
            if ($urandom_range(0, 19) == 0) rsp_quiet <= ~rsp_quiet;
         end else if (stall_now > 0) begin
            stall_now--;
         end
         rsp_stall  <= stall_now;
         rsp_tready <= (stall_now == 0) && (hold_left == 0);
      end
   end

   // one long receiver stall in the middle of a drain, to back up the input
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_armed <= 1'b1;
      end else if (hold_armed && rsp_count >= HOLD_AT && rsp_tvalid && !rsp_tlast) begin
         hold_left  <= HOLD_CYCLES;
         hold_armed <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int                batch_no;
      int                random_items;
      int                len;
      logic [DATA_W-1:0] prev;
      logic [DATA_W-1:0] value;

      // single element at the top of the range
      add_request(32'h7fff_ffff, 1'b1);
      // extremes, zero, both signs, duplicate minimum
      add_request(32'h8000_0000, 1'b0);
      add_request(32'h7fff_ffff, 1'b0);
      add_request(32'h0000_0000, 1'b0);
      add_request(32'hffff_ffff, 1'b0);
      add_request(32'h0000_0001, 1'b0);
      add_request(32'h8000_0000, 1'b1);
      // strictly descending arrival
      add_request(32'd40, 1'b0);
      add_request(32'd30, 1'b0);
      add_request(32'd20, 1'b0);
      add_request(32'd10, 1'b0);
      add_request(-32'sd10, 1'b1);
      // all equal
      add_request(32'd5, 1'b0);
      add_request(32'd5, 1'b0);
      add_request(32'd5, 1'b1);
      // two elements already in order
      add_request(32'h8000_0001, 1'b0);
      add_request(32'hffff_fffe, 1'b1);

      batch_no     = 0;
      random_items = 0;
      prev         = '0;
      while (random_items < 200) begin
         if (batch_no == 2)
            len = MAX_ELEMENTS;
         else if (batch_no == 5)
            len = MAX_ELEMENTS + 2;   // mark lands on a dropped element
         else if ($urandom_range(0, 15) == 0)
            len = $urandom_range(16, 40);
         else
            len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            value = draw_element(prev);
            add_request(value, i == len - 1);
            prev = value;
            if (i < MAX_ELEMENTS) random_items++;
         end
         batch_no++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_tvalid || expected_sorted.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("covered %0d batches of up to %0d elements, %0d elements sent, %0d results",
               batch_count, MAX_ELEMENTS, sent_count, rsp_count);
      $display("%0d elements dropped past a full store, %0d mismatches",
               drop_count, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/isrt_pkg.sv
rtl/isrt_cell.sv
rtl/integer_array_sorter_top.sv
verif/integer_array_sorter_top_tb.sv
